[hdl/sit_pkg.sv]
package sit_pkg;

    // Classification of one segment pair, in priority order after a crossing.
    typedef enum logic [2:0] {
        KIND_CROSS        = 3'd0,
        KIND_SHARED_START = 3'd1,
        KIND_SHARED_END   = 3'd2,
        KIND_PARALLEL     = 3'd3,
        KIND_OUTSIDE      = 3'd4
    } kind_t;

endpackage

[hdl/segment_intersection_test.sv]
// Segment crossing test for two plane segments A and B given as signed fixed-point points.
// Input channel: in_valid / in_stall carry one beat holding both segments' end points.
// A beat is taken at a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry one result beat per input beat, in order:
// crosses, result_kind, and the crossing point (zero unless the segments cross).
// Each result passes the pipeline stages listed below and is then held on the output register.
// Throughput: one beat per cycle while in_stall is low.
// The pipeline has four arithmetic stages (differences, products, cross products,
// sign fix-up), one classification stage, and one restoring-division step per bit
// of the segment A extent, COORD_WIDTH steps per coordinate in two parallel lanes.
// Reset clears every valid bit; no beat is in flight afterwards.
// When the receiver stalls, the waiting result holds on the output register and one
// more result is caught in a skid register; in_stall then rises and the whole pipeline
// holds until the skid register drains. in_stall comes straight from a register.
module segment_intersection_test #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] a_start_y,
    input  logic signed [COORD_WIDTH-1:0] a_start_z,
    input  logic signed [COORD_WIDTH-1:0] a_end_y,
    input  logic signed [COORD_WIDTH-1:0] a_end_z,
    input  logic signed [COORD_WIDTH-1:0] b_start_y,
    input  logic signed [COORD_WIDTH-1:0] b_start_z,
    input  logic signed [COORD_WIDTH-1:0] b_end_y,
    input  logic signed [COORD_WIDTH-1:0] b_end_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          crosses,
    output sit_pkg::kind_t                result_kind,
    output logic signed [COORD_WIDTH-1:0] cross_y,
    output logic signed [COORD_WIDTH-1:0] cross_z
);
    import sit_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int W1    = W + 1;       // coordinate differences
    localparam int PW    = 2 * W + 2;   // single products
    localparam int NW    = 2 * W + 3;   // cross products
    localparam int DW    = 2 * W + 1;   // divisor and remainder magnitude
    localparam int XW    = DW + 2;      // partial remainder before reduction
    localparam int NSTEP = W;           // quotient bits per coordinate

    typedef struct packed {
        logic signed [W-1:0]  p0y;
        logic signed [W-1:0]  p0z;
        logic signed [W1-1:0] s1y;
        logic signed [W1-1:0] s1z;
        logic                 same_start;
        logic                 same_end;
    } carry_t;

    typedef struct packed {
        carry_t               c;
        logic signed [W1-1:0] s2y;
        logic signed [W1-1:0] s2z;
        logic signed [W1-1:0] dy;
        logic signed [W1-1:0] dz;
    } s1_t;

    typedef struct packed {
        carry_t               c;
        logic signed [PW-1:0] den_a;
        logic signed [PW-1:0] den_b;
        logic signed [PW-1:0] sn_a;
        logic signed [PW-1:0] sn_b;
        logic signed [PW-1:0] tn_a;
        logic signed [PW-1:0] tn_b;
    } s2_t;

    typedef struct packed {
        carry_t               c;
        logic signed [NW-1:0] den;
        logic signed [NW-1:0] snum;
        logic signed [NW-1:0] tnum;
    } s3_t;

    typedef struct packed {
        kind_t                kind;
        logic signed [W-1:0]  p0y;
        logic signed [W-1:0]  p0z;
        logic                 neg_y;
        logic                 neg_z;
        logic [W-1:0]         mag_y;
        logic [W-1:0]         mag_z;
        logic [DW-1:0]        den;
        logic [DW-1:0]        tnum;
        logic [DW-1:0]        rem_y;
        logic [DW-1:0]        rem_z;
        logic [W-1:0]         q_y;
        logic [W-1:0]         q_z;
    } dstage_t;

    typedef struct packed {
        logic [DW-1:0] rem;
        logic [W-1:0]  q;
    } step_t;

    typedef struct packed {
        logic                crosses;
        kind_t               kind;
        logic signed [W-1:0] cross_y;
        logic signed [W-1:0] cross_z;
    } res_t;

    // One step of the scaled division: brings in one multiplier bit, so that
    // tnum * m_prefix = q * den + rem stays true with rem below den.
    function automatic step_t div_step(
        input logic [DW-1:0] rem,
        input logic [W-1:0]  q,
        input logic          bit_in,
        input logic [DW-1:0] tnum,
        input logic [DW-1:0] den
    );
        logic [XW-1:0] x;
        logic [XW-1:0] d1;
        logic [XW-1:0] d2;
        step_t         r;
        x  = {1'b0, rem, 1'b0} + (bit_in ? XW'(tnum) : XW'(0));
        d1 = XW'(den);
        d2 = {1'b0, den, 1'b0};
        priority if (x >= d2)
        begin
            r.rem = DW'(x - d2);
            r.q   = (q << 1) + W'(2);
        end
        else if (x >= d1)
        begin
            r.rem = DW'(x - d1);
            r.q   = (q << 1) + W'(1);
        end
        else
        begin
            r.rem = DW'(x);
            r.q   = q << 1;
        end
        return r;
    endfunction

    logic    en;
    s1_t     s1_reg, s1_next;
    logic    s1_valid_reg;
    s2_t     s2_reg, s2_next;
    logic    s2_valid_reg;
    s3_t     s3_reg, s3_next;
    logic    s3_valid_reg;
    s3_t     s4_reg, s4_next;
    logic    s4_valid_reg;
    dstage_t div0_next;
    dstage_t div_reg [0:NSTEP];
    dstage_t div_next [1:NSTEP];
    logic    div_valid_reg [0:NSTEP];
    res_t    res;
    res_t    out_reg, out_next;
    logic    out_valid_reg, out_valid_next;
    res_t    skid_reg, skid_next;
    logic    skid_valid_reg, skid_valid_next;

    // The whole pipeline moves together unless the skid register is occupied.
    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    // Stage 1: direction vectors, start offset and shared end point flags.
    always_comb
    begin
        s1_next.c.p0y        = a_start_y;
        s1_next.c.p0z        = a_start_z;
        s1_next.c.s1y        = W1'(a_end_y) - W1'(a_start_y);
        s1_next.c.s1z        = W1'(a_end_z) - W1'(a_start_z);
        s1_next.c.same_start = (a_start_y == b_start_y) && (a_start_z == b_start_z);
        s1_next.c.same_end   = (a_end_y == b_end_y) && (a_end_z == b_end_z);
        s1_next.s2y          = W1'(b_end_y) - W1'(b_start_y);
        s1_next.s2z          = W1'(b_end_z) - W1'(b_start_z);
        s1_next.dy           = W1'(a_start_y) - W1'(b_start_y);
        s1_next.dz           = W1'(a_start_z) - W1'(b_start_z);
    end

    // Stage 2: the six products of the three cross products.
    always_comb
    begin
        s2_next.c     = s1_reg.c;
        s2_next.den_a = PW'(s1_reg.c.s1y) * PW'(s1_reg.s2z);
        s2_next.den_b = PW'(s1_reg.s2y) * PW'(s1_reg.c.s1z);
        s2_next.sn_a  = PW'(s1_reg.c.s1y) * PW'(s1_reg.dz);
        s2_next.sn_b  = PW'(s1_reg.c.s1z) * PW'(s1_reg.dy);
        s2_next.tn_a  = PW'(s1_reg.s2y) * PW'(s1_reg.dz);
        s2_next.tn_b  = PW'(s1_reg.s2z) * PW'(s1_reg.dy);
    end

    // Stage 3: cross products.
    always_comb
    begin
        s3_next.c    = s2_reg.c;
        s3_next.den  = NW'(s2_reg.den_a) - NW'(s2_reg.den_b);
        s3_next.snum = NW'(s2_reg.sn_a) - NW'(s2_reg.sn_b);
        s3_next.tnum = NW'(s2_reg.tn_a) - NW'(s2_reg.tn_b);
    end

    // Stage 4: make the denominator non-negative.
    always_comb
    begin
        s4_next = s3_reg;
        if (s3_reg.den[NW-1])
        begin
            s4_next.den  = NW'(0) - s3_reg.den;
            s4_next.snum = NW'(0) - s3_reg.snum;
            s4_next.tnum = NW'(0) - s3_reg.tnum;
        end
    end

    // Stage 5: classify the pair and set up both division lanes.
    always_comb
    begin
        logic              t_in;
        logic              s_in;
        logic signed [W:0] abs_y;
        logic signed [W:0] abs_z;
        t_in  = !s4_reg.tnum[NW-1] && (s4_reg.tnum != '0) && (s4_reg.tnum < s4_reg.den);
        s_in  = !s4_reg.snum[NW-1] && (s4_reg.snum != '0) && (s4_reg.snum < s4_reg.den);
        abs_y = s4_reg.c.s1y[W] ? (W1'(0) - s4_reg.c.s1y) : s4_reg.c.s1y;
        abs_z = s4_reg.c.s1z[W] ? (W1'(0) - s4_reg.c.s1z) : s4_reg.c.s1z;

        priority if (s4_reg.c.same_start)
            div0_next.kind = KIND_SHARED_START;
        else if (s4_reg.c.same_end)
            div0_next.kind = KIND_SHARED_END;
        else if (s4_reg.den == '0)
            div0_next.kind = KIND_PARALLEL;
        else if (!(t_in && s_in))
            div0_next.kind = KIND_OUTSIDE;
        else
            div0_next.kind = KIND_CROSS;

        div0_next.p0y   = s4_reg.c.p0y;
        div0_next.p0z   = s4_reg.c.p0z;
        div0_next.neg_y = s4_reg.c.s1y[W];
        div0_next.neg_z = s4_reg.c.s1z[W];
        div0_next.mag_y = abs_y[W-1:0];
        div0_next.mag_z = abs_z[W-1:0];
        div0_next.den   = s4_reg.den[DW-1:0];
        div0_next.tnum  = (t_in && s_in) ? s4_reg.tnum[DW-1:0] : '0;
        div0_next.rem_y = '0;
        div0_next.rem_z = '0;
        div0_next.q_y   = '0;
        div0_next.q_z   = '0;
    end

    // Front stage registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg     <= s1_next;
            s2_reg     <= s2_next;
            s3_reg     <= s3_next;
            s4_reg     <= s4_next;
            div_reg[0] <= div0_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            div_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg     <= in_valid;
            s2_valid_reg     <= s1_valid_reg;
            s3_valid_reg     <= s2_valid_reg;
            s4_valid_reg     <= s3_valid_reg;
            div_valid_reg[0] <= s4_valid_reg;
        end
    end

    // Division pipeline: stage k takes multiplier bit NSTEP-1-k, MSB first.
    for (genvar k = 0; k < NSTEP; k++)
    begin : g_div
        localparam int BI = NSTEP - 1 - k;
        step_t sy;
        step_t sz;

        always_comb
        begin
            sy = div_step(div_reg[k].rem_y, div_reg[k].q_y, div_reg[k].mag_y[BI],
                          div_reg[k].tnum, div_reg[k].den);
            sz = div_step(div_reg[k].rem_z, div_reg[k].q_z, div_reg[k].mag_z[BI],
                          div_reg[k].tnum, div_reg[k].den);
            div_next[k+1]       = div_reg[k];
            div_next[k+1].rem_y = sy.rem;
            div_next[k+1].q_y   = sy.q;
            div_next[k+1].rem_z = sz.rem;
            div_next[k+1].q_z   = sz.q;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_reg[k+1] <= div_next[k+1];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                div_valid_reg[k+1] <= div_valid_reg[k];
            end
        end
    end

    // Crossing point: start of A plus the signed, truncated quotient.
    always_comb
    begin
        res.kind = div_reg[NSTEP].kind;
        if (div_reg[NSTEP].kind == KIND_CROSS)
        begin
            res.crosses = 1'b1;
            res.cross_y = div_reg[NSTEP].p0y
                        + (div_reg[NSTEP].neg_y ? (W'(0) - div_reg[NSTEP].q_y)
                                                : div_reg[NSTEP].q_y);
            res.cross_z = div_reg[NSTEP].p0z
                        + (div_reg[NSTEP].neg_z ? (W'(0) - div_reg[NSTEP].q_z)
                                                : div_reg[NSTEP].q_z);
        end
        else
        begin
            res.crosses = 1'b0;
            res.cross_y = '0;
            res.cross_z = '0;
        end
    end

    // Output register with a one-beat skid register behind it.
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = res;
                out_valid_next = div_valid_reg[NSTEP];
            end
        end
        else if (en && div_valid_reg[NSTEP])
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign crosses     = out_reg.crosses;
    assign result_kind = out_reg.kind;
    assign cross_y     = out_reg.cross_y;
    assign cross_z     = out_reg.cross_z;

endmodule

[hdl/sit_checker.sv]
module sit_checker #(
    parameter int COORD_WIDTH = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          crosses,
    input sit_pkg::kind_t                result_kind,
    input logic signed [COORD_WIDTH-1:0] cross_y,
    input logic signed [COORD_WIDTH-1:0] cross_z
);
    import sit_pkg::*;

    // A stalled result beat stays put until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_kind)
            && $stable(cross_y) && $stable(cross_z))
        else $error("stalled result beat changed");

    // The crossing flag agrees with the classification.
    a_flag_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> crosses == (result_kind == KIND_CROSS))
        else $error("crosses disagrees with result_kind");

    // Without a crossing the point reads as zero.
    a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !crosses |-> cross_y == '0 && cross_z == '0)
        else $error("crossing point not zero for a non-crossing beat");

    // The input side only stalls after the output side held a beat back.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stalled without an output stall");

endmodule

bind segment_intersection_test sit_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sit_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .crosses     (crosses),
    .result_kind (result_kind),
    .cross_y     (cross_y),
    .cross_z     (cross_z)
);

[tb/tb_segment_intersection_test.sv]
`timescale 1ns / 100ps

module tb_segment_intersection_test;

    import sit_pkg::*;

    localparam int COORD_W = 16;
    localparam int IDLE_PCT = 22;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef logic signed [COORD_W-1:0] coord_t;

    // One input beat: both segments' end points.
    typedef struct {
        coord_t a_start_y;
        coord_t a_start_z;
        coord_t a_end_y;
        coord_t a_end_z;
        coord_t b_start_y;
        coord_t b_start_z;
        coord_t b_end_y;
        coord_t b_end_z;
    } seg_pair_t;

    // One result beat.
    typedef struct {
        logic   crosses;
        kind_t  kind;
        coord_t cross_y;
        coord_t cross_z;
    } crossing_t;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   in_valid = 1'b0;
    logic   in_stall;
    coord_t a_start_y = '0;
    coord_t a_start_z = '0;
    coord_t a_end_y = '0;
    coord_t a_end_z = '0;
    coord_t b_start_y = '0;
    coord_t b_start_z = '0;
    coord_t b_end_y = '0;
    coord_t b_end_z = '0;
    logic   out_valid;
    logic   out_stall = 1'b0;
    logic   crosses;
    kind_t  result_kind;
    coord_t cross_y;
    coord_t cross_z;

    seg_pair_t pending_pairs[$];
    crossing_t expected_crossings[$];
    seg_pair_t on_offer;
    bit        idle_on = 1'b1;
    int        holdoffs_asked = 0;
    int        holdoffs_served = 0;
    int        holdoff_left = 0;
    int        mismatches = 0;
    int        quiet_cycles = 0;

    segment_intersection_test #(
        .COORD_WIDTH(COORD_W)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .a_start_y  (a_start_y),
        .a_start_z  (a_start_z),
        .a_end_y    (a_end_y),
        .a_end_z    (a_end_z),
        .b_start_y  (b_start_y),
        .b_start_z  (b_start_z),
        .b_end_y    (b_end_y),
        .b_end_z    (b_end_z),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .crosses    (crosses),
        .result_kind(result_kind),
        .cross_y    (cross_y),
        .cross_z    (cross_z)
    );

    // Free-running clock, 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Exact crossing test: cross products fit comfortably in 64 bits at this width.
    function automatic crossing_t predict_crossing(seg_pair_t p);
        longint s1y, s1z, s2y, s2z, dy, dz, den, snum, tnum;
        crossing_t r;
        s1y = longint'(p.a_end_y) - longint'(p.a_start_y);
        s1z = longint'(p.a_end_z) - longint'(p.a_start_z);
        s2y = longint'(p.b_end_y) - longint'(p.b_start_y);
        s2z = longint'(p.b_end_z) - longint'(p.b_start_z);
        dy = longint'(p.a_start_y) - longint'(p.b_start_y);
        dz = longint'(p.a_start_z) - longint'(p.b_start_z);
        den = s1y * s2z - s2y * s1z;
        snum = s1y * dz - s1z * dy;
        tnum = s2y * dz - s2z * dy;
        if (den < 0)
        begin
            den = -den;
            snum = -snum;
            tnum = -tnum;
        end
        r.crosses = 1'b0;
        r.cross_y = '0;
        r.cross_z = '0;
        if (p.a_start_y == p.b_start_y && p.a_start_z == p.b_start_z)
            r.kind = KIND_SHARED_START;
        else if (p.a_end_y == p.b_end_y && p.a_end_z == p.b_end_z)
            r.kind = KIND_SHARED_END;
        else if (den == 0)
            r.kind = KIND_PARALLEL;
        else if (snum <= 0 || snum >= den || tnum <= 0 || tnum >= den)
            r.kind = KIND_OUTSIDE;
        else
        begin
            // Signed division in SystemVerilog truncates toward zero.
            r.kind = KIND_CROSS;
            r.crosses = 1'b1;
            r.cross_y = COORD_W'(longint'(p.a_start_y) + tnum * s1y / den);
            r.cross_z = COORD_W'(longint'(p.a_start_z) + tnum * s1z / den);
        end
        return r;
    endfunction

    function automatic seg_pair_t make_pair(int ay0, int az0, int ay1, int az1,
                                            int by0, int bz0, int by1, int bz1);
        seg_pair_t p;
        p.a_start_y = COORD_W'(ay0);
        p.a_start_z = COORD_W'(az0);
        p.a_end_y = COORD_W'(ay1);
        p.a_end_z = COORD_W'(az1);
        p.b_start_y = COORD_W'(by0);
        p.b_start_z = COORD_W'(bz0);
        p.b_end_y = COORD_W'(by1);
        p.b_end_z = COORD_W'(bz1);
        return p;
    endfunction

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // Random pair, mostly built to cross or to sit on one of the boundary cases.
    function automatic seg_pair_t make_random_pair();
        int sel, py, pz, d1y, d1z, d2y, d2z, k1, k2, k3, k4, oy, oz;
        seg_pair_t p;
        sel = $urandom_range(99);
        py = rand_between(-8000, 8000);
        pz = rand_between(-8000, 8000);
        d1y = rand_between(-2000, 2000);
        d1z = rand_between(-2000, 2000);
        d2y = rand_between(-2000, 2000);
        d2z = rand_between(-2000, 2000);
        k1 = rand_between(1, 3);
        k2 = rand_between(1, 3);
        k3 = rand_between(1, 3);
        k4 = rand_between(1, 3);
        oy = rand_between(-5000, 5000);
        oz = rand_between(-5000, 5000);
        p.a_start_y = COORD_W'($urandom);
        p.a_start_z = COORD_W'($urandom);
        p.a_end_y = COORD_W'($urandom);
        p.a_end_z = COORD_W'($urandom);
        p.b_start_y = COORD_W'($urandom);
        p.b_start_z = COORD_W'($urandom);
        p.b_end_y = COORD_W'($urandom);
        p.b_end_z = COORD_W'($urandom);
        if (sel < 35)
            // Both segments pass through one interior point.
            p = make_pair(py - k1 * d1y, pz - k1 * d1z, py + k2 * d1y, pz + k2 * d1z,
                          py - k3 * d2y, pz - k3 * d2z, py + k4 * d2y, pz + k4 * d2z);
        else if (sel < 45)
            // B starts exactly on the interior of A, so one parameter is zero.
            p = make_pair(py - k1 * d1y, pz - k1 * d1z, py + k2 * d1y, pz + k2 * d1z,
                          py, pz, py + k4 * d2y, pz + k4 * d2z);
        else if (sel < 55)
        begin
            // Parallel copies, reversed copies and zero-length segments.
            p = make_pair(py, pz, py + d1y, pz + d1z,
                          py + oy, pz + oz, py + oy + d1y, pz + oz + d1z);
            if (sel < 49)
                p = make_pair(py, pz, py + d1y, pz + d1z,
                              py + oy + d1y, pz + oz + d1z, py + oy, pz + oz);
            else if (sel < 51)
            begin
                p.b_end_y = p.b_start_y;
                p.b_end_z = p.b_start_z;
            end
        end
        else if (sel < 62)
        begin
            p.b_start_y = p.a_start_y;
            p.b_start_z = p.a_start_z;
        end
        else if (sel < 69)
        begin
            p.b_end_y = p.a_end_y;
            p.b_end_z = p.a_end_z;
        end
        else if (sel < 80)
            p = make_pair(rand_between(-128, 128), rand_between(-128, 128),
                          rand_between(-128, 128), rand_between(-128, 128),
                          rand_between(-128, 128), rand_between(-128, 128),
                          rand_between(-128, 128), rand_between(-128, 128));
        return p;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Appends one beat to the queue the sender draws from.
    task automatic add_pair(seg_pair_t p);
        pending_pairs = {pending_pairs, p};
    endtask

    // Sender: predicts each beat as it is taken and offers the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                expected_crossings = {expected_crossings, predict_crossing(on_offer)};
            if (!in_valid || !in_stall)
            begin
                if (pending_pairs.size() != 0 &&
                    !(idle_on && $urandom_range(99) < IDLE_PCT))
                begin
                    on_offer = pending_pairs.pop_front();
                    a_start_y <= on_offer.a_start_y;
                    a_start_z <= on_offer.a_start_z;
                    a_end_y <= on_offer.a_end_y;
                    a_end_z <= on_offer.a_end_z;
                    b_start_y <= on_offer.b_start_y;
                    b_start_z <= on_offer.b_start_z;
                    b_end_y <= on_offer.b_end_y;
                    b_end_z <= on_offer.b_end_z;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is asked for.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (holdoff_left == 0 && holdoffs_served != holdoffs_asked)
            begin
                holdoffs_served++;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left != 0)
            begin
                holdoff_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Result checker: each taken beat against the oldest prediction.
    always @(posedge clk)
    begin
        crossing_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_crossings.size() == 0)
                report_mismatch($sformatf("result with nothing expected: kind %0d (%0d,%0d)",
                                          result_kind, cross_y, cross_z));
            else
            begin
                want = expected_crossings.pop_front();
                if (crosses !== want.crosses)
                    report_mismatch($sformatf("crosses %b, expected %b",
                                              crosses, want.crosses));
                if (result_kind !== want.kind)
                    report_mismatch($sformatf("result_kind %0d, expected %0d",
                                              result_kind, want.kind));
                if (cross_y !== want.cross_y)
                    report_mismatch($sformatf("cross_y %0d, expected %0d",
                                              cross_y, want.cross_y));
                if (cross_z !== want.cross_z)
                    report_mismatch($sformatf("cross_z %0d, expected %0d",
                                              cross_z, want.cross_z));
            end
        end
    end

    // Watchdog: too long without a beat on either channel ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_segment_intersection_test NOT OK");
                $finish;
            end
        end
    end

    // Waits until every queued beat has been taken and every result has come back.
    task automatic wait_all_returned();
        while (pending_pairs.size() != 0 || in_valid || expected_crossings.size() != 0)
            @(negedge clk);
    endtask

    // Stimulus sequence.
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed beats: extremes, every outcome and the boundary cases.
        add_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        add_pair(make_pair(32767, 32767, 32767, 32767,
                           32767, 32767, 32767, 32767));
        add_pair(make_pair(-32768, -32768, -32768, -32768,
                           -32768, -32768, -32768, -32768));
        add_pair(make_pair(0, 0, 64, 64, 0, 64, 64, 0));
        add_pair(make_pair(64, 64, 0, 0, 0, 64, 64, 0));
        add_pair(make_pair(-32768, -32768, 32767, 32767,
                           -32768, 32767, 32767, -32768));
        add_pair(make_pair(-32768, 32767, 32767, -32768,
                           -32768, -32768, 32767, 32767));
        add_pair(make_pair(32767, -32768, -32768, 32767,
                           32767, 32767, -32768, -32768));
        add_pair(make_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767));
        add_pair(make_pair(0, 0, 100, 100, 50, 0, 100, 100));
        add_pair(make_pair(0, 0, 100, 0, 0, 10, 100, 10));
        add_pair(make_pair(0, 0, 100, 0, 50, 0, 150, 0));
        add_pair(make_pair(5, 5, 5, 5, 0, 0, 10, 10));
        add_pair(make_pair(0, 0, 10, 10, 3, 7, 3, 7));
        add_pair(make_pair(0, 0, 64, 0, 64, -64, 64, 64));
        add_pair(make_pair(0, 0, 64, 0, 32, 0, 32, 64));
        add_pair(make_pair(0, 0, 10, 10, 100, 0, 0, 100));
        add_pair(make_pair(-100, -50, -20, -90, -90, -100, -30, -10));
        add_pair(make_pair(1, 0, -6, 5, -4, -1, 0, 6));
        add_pair(make_pair(0, 0, 64, 64, 128, 0, 0, 0));
        add_pair(make_pair(7, -3, 90, 40, 7, -3, 90, 40));

        // The sender pauses here until every result is back.
        wait_all_returned();

        // Long receiver hold-off with the sender offering every cycle.
        idle_on = 1'b0;
        holdoffs_asked++;
        for (int i = 0; i < 100; i++)
            add_pair(make_random_pair());
        wait_all_returned();

        // Random beats in chunks; the middle chunks run with no idling at all.
        for (int chunk = 0; chunk < 16; chunk++)
        begin
            idle_on = (chunk < 6 || chunk > 8);
            for (int i = 0; i < 95; i++)
                add_pair(make_random_pair());
            while (pending_pairs.size() > 4)
                @(negedge clk);
        end

        wait_all_returned();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("tb_segment_intersection_test OK");
        else
            $display("tb_segment_intersection_test NOT OK");
        $finish;
    end

endmodule

[files.f]
hdl/sit_pkg.sv
hdl/segment_intersection_test.sv
hdl/sit_checker.sv
tb/tb_segment_intersection_test.sv
